[sv/point_in_bounded_volumes_check_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the bounded volume checker
// ---------------------------------------------------------------------------
`ifndef POINT_IN_BOUNDED_VOLUMES_CHECK_MACROS_SVH
`define POINT_IN_BOUNDED_VOLUMES_CHECK_MACROS_SVH
`ifndef SYNTHESIS
`define PIBV_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("violated");
`define PIBV_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("violated");
`else
`define PIBV_ASSERT_IMP(lbl, clk, rstn, a, c)
`define PIBV_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

[sv/pibv_pkg.sv]
// ---------------------------------------------------------------------------
// pibv_pkg
// Shared types and constants of the bounded volume checker.
// ---------------------------------------------------------------------------
package pibv_pkg;
  localparam int WORDS_PER_ENTRY = 16;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;
  localparam logic [0:0] CFG_IGNORE = 1'b0;
  localparam logic [0:0] CFG_COUNT  = 1'b1;
  localparam logic [3:0] W_OFFSET = 4'd9;
  localparam logic [3:0] W_SIZE   = 4'd12;
  localparam logic [3:0] W_HEIGHT = 4'd13;
  localparam logic [3:0] W_TYPE   = 4'd14;
  localparam logic [3:0] W_ENABLE = 4'd15;

  // Command from front to back
  typedef struct packed {
    logic        op;
    logic [2:0]  entry;
    logic [3:0]  word_sel;
    logic [31:0] value;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ENA, S_MUL, S_ROW, S_OFF, S_CHK, S_SQ, S_CMP, S_DONE
  } bstate_t;
endpackage

[sv/pibv_front.sv]
// ---------------------------------------------------------------------------
// pibv_front
// Input stage and two-entry command queue ahead of the engine.
// ---------------------------------------------------------------------------
module pibv_front import pibv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];

  // store queue entries
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem_r[wp_r] <= in_cmd;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_valid && q_ready) ? 1 : 0);
    end
  end
endmodule

[sv/pibv_back.sv]
// ---------------------------------------------------------------------------
// pibv_back
// Table memory and sequential per-entry transform and bounds test.
// ---------------------------------------------------------------------------
module pibv_back import pibv_pkg::*; #(
  parameter int MAX_RESTRICTIONS = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  cmd_t       q_cmd,
  input  logic       ignore,
  input  logic [3:0] count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_inside_res
);
  localparam int EW = (MAX_RESTRICTIONS > 1) ? $clog2(MAX_RESTRICTIONS) : 1;
  localparam int AW = EW + 4;
  localparam int KW = $clog2(MAX_RESTRICTIONS + 1);
  localparam int LW = 52;

  logic [31:0] tab_r [MAX_RESTRICTIONS*WORDS_PER_ENTRY];
  logic [31:0] rd_r;
  logic [AW-1:0] ra;

  bstate_t st_r, st_nxt;
  cmd_t    cmd_r;
  logic [KW-1:0] k_r, k_nxt, lim;
  logic [1:0] i_r, i_nxt, j_r, j_nxt;
  logic signed [63:0] prod_r;
  logic signed [LW-1:0] acc_r, acc_nxt;
  logic [15+FRAC_BITS:0] lows_r, lows_nxt;
  logic signed [LW-1:0] loc_r [3];
  logic signed [31:0] size_r, size_nxt;
  logic [63:0] sqa_r, sqb_r;
  logic [1:0] sq_r, sq_nxt;
  logic [63:0] sqsum_r;
  logic [63:0] mul_a, mul_b;
  logic [63:0] sq_prod;
  logic [LW-1:0] ax, ay;
  logic fail_r, fail_nxt, res_r, res_nxt;
  logic [3:0] wsel;
  logic signed [31:0] pj;

  // clamp entry count
  always_comb begin
    if (int'(count) > MAX_RESTRICTIONS) lim = KW'(MAX_RESTRICTIONS);
    else lim = KW'(count);
  end

  // address the word the next state consumes
  assign ra = {k_nxt[EW-1:0], wsel};
  assign pj = (j_r == 2'd0) ? $signed(cmd_r.px) :
              (j_r == 2'd1) ? $signed(cmd_r.py) : $signed(cmd_r.pz);
  assign ax = loc_r[0][LW-1] ? LW'(-loc_r[0]) : LW'(loc_r[0]);
  assign ay = loc_r[1][LW-1] ? LW'(-loc_r[1]) : LW'(loc_r[1]);

  // pick word address for the next state
  always_comb begin
    unique case (st_nxt)
      S_MUL:   wsel = {i_nxt, 2'b00} - 4'(i_nxt) + 4'(j_nxt);
      S_OFF:   wsel = W_OFFSET + 4'(i_nxt);
      S_SQ:    wsel = (sq_nxt == 2'd0) ? W_SIZE : W_HEIGHT;
      S_CMP:   wsel = W_TYPE;
      default: wsel = W_ENABLE;
    endcase
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid && q_cmd.op == OP_LOAD &&
        int'(q_cmd.entry) < MAX_RESTRICTIONS)
      tab_r[AW'({q_cmd.entry, q_cmd.word_sel})] <= q_cmd.value;
    rd_r <= tab_r[ra];
  end

  // shared squarer operands
  always_comb begin
    mul_a = (sq_r == 2'd0) ? 64'(ax) : (sq_r == 2'd1) ? 64'(ay) :
            64'(size_r[31] ? -size_r : size_r);
    mul_b = mul_a;
  end

  assign sq_prod = mul_a[31:0] * mul_b[31:0];

  // state register and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; k_r <= '0; i_r <= '0; j_r <= '0; sq_r <= '0;
      res_r <= 1'b1; fail_r <= 1'b0;
    end else begin
      st_r <= st_nxt; k_r <= k_nxt; i_r <= i_nxt; j_r <= j_nxt; sq_r <= sq_nxt;
      res_r <= res_nxt; fail_r <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid) cmd_r <= q_cmd;
    prod_r <= $signed(rd_r) * pj;
    acc_r  <= acc_nxt;
    lows_r <= lows_nxt;
    size_r <= size_nxt;
    if (st_r == S_OFF)
      loc_r[i_r] <= acc_r + LW'(lows_r >> FRAC_BITS) + LW'($signed(rd_r));
    if (st_r == S_SQ) begin
      if (sq_r == 2'd0) sqa_r <= sq_prod;
      if (sq_r == 2'd1) sqb_r <= sq_prod;
      if (sq_r == 2'd2) sqsum_r <= sq_prod;
    end
  end

  assign q_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_DONE);
  assign out_inside_res = res_r;

  // sequencer
  always_comb begin
    st_nxt = st_r; k_nxt = k_r; i_nxt = i_r; j_nxt = j_r; sq_nxt = sq_r;
    acc_nxt = acc_r; lows_nxt = lows_r; size_nxt = size_r;
    res_nxt = res_r; fail_nxt = fail_r;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid && q_cmd.op == OP_TEST) begin
          k_nxt = '0; res_nxt = 1'b1;
          st_nxt = ignore ? S_DONE : S_ENA;
        end
      end
      S_ENA: begin
        // rd_r holds the enable word of entry k
        if (k_r >= lim) st_nxt = S_DONE;
        else if (rd_r == 32'd0) k_nxt = k_r + 1'b1;
        else begin
          i_nxt = '0; j_nxt = '0; acc_nxt = '0; lows_nxt = '0; st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // rotation word is in rd_r; product lands next cycle
        st_nxt = S_ROW;
      end
      S_ROW: begin
        acc_nxt  = acc_r + LW'(prod_r >>> FRAC_BITS);
        lows_nxt = lows_r + (16+FRAC_BITS)'(prod_r[FRAC_BITS-1:0]);
        if (j_r == 2'd2) begin
          st_nxt = S_OFF;
        end else begin
          j_nxt = j_r + 2'd1; st_nxt = S_MUL;
        end
      end
      S_OFF: begin
        // offset word is in rd_r; local coordinate is stored this cycle
        acc_nxt = '0; lows_nxt = '0; j_nxt = '0;
        if (i_r == 2'd2) begin
          st_nxt = S_CHK;
        end else begin
          i_nxt = i_r + 2'd1; st_nxt = S_MUL;
        end
      end
      S_CHK: begin
        st_nxt = S_SQ; sq_nxt = '0; fail_nxt = 1'b0;
      end
      S_SQ: begin
        // rd_r holds size first, height afterwards
        if (sq_r == 2'd0) size_nxt = $signed(rd_r);
        if (sq_r == 2'd1) begin
          if (loc_r[2] < 0 || loc_r[2] > LW'($signed(rd_r))) fail_nxt = 1'b1;
        end
        if (sq_r == 2'd2) st_nxt = S_CMP;
        else sq_nxt = sq_r + 2'd1;
      end
      S_CMP: begin
        // rd_r holds the shape type
        if (rd_r == 32'd0) begin
          if (ax > (LW'(1) << 31) || ay > (LW'(1) << 31) ||
              (65'(sqa_r) + 65'(sqb_r) > 65'(sqsum_r))) fail_nxt = 1'b1;
        end else begin
          if ($signed({1'b0, ax, 1'b0}) > (LW+2)'(size_r) ||
              $signed({1'b0, ay, 1'b0}) > (LW+2)'(size_r)) fail_nxt = 1'b1;
        end
        if (fail_nxt) begin
          res_nxt = 1'b0; st_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 1'b1; st_nxt = S_ENA;
        end
      end
      S_DONE: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

[sv/point_in_bounded_volumes_check.sv]
// A load passes the two-entry queue and is written while the engine is idle;
// a test steps ENA per entry and MUL/ROW/OFF/CHK/SQ/CMP per enabled one to DONE.
// Throughput: one test at a time; loads queue behind it in a two-entry queue.
// Reset: synchronous active-low rst_n clears control and config; table is unwritten.
// ---------------------------------------------------------------------------
// point_in_bounded_volumes_check
// Tests points against a loaded table of cylinder and box volumes.
// ---------------------------------------------------------------------------
`include "point_in_bounded_volumes_check_macros.svh"
module point_in_bounded_volumes_check import pibv_pkg::*; #(
  parameter int MAX_RESTRICTIONS = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [2:0]  in_entry,
  input  logic [3:0]  in_word_sel,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_inside_res
);
  logic ignore_r;
  logic [3:0] count_r;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;
  // hold config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_r <= 1'b0; count_r <= 4'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IGNORE) ignore_r <= cfg_data[0];
      if (cfg_index == CFG_COUNT) count_r <= cfg_data[3:0];
    end
  end

  assign in_cmd = '{op: in_op, entry: in_entry, word_sel: in_word_sel, value: in_value,
                    px: in_point_x, py: in_point_y, pz: in_point_z};

  pibv_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_cmd,
                      .q_valid, .q_ready, .q_cmd);

  pibv_back #(.MAX_RESTRICTIONS(MAX_RESTRICTIONS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .ignore(ignore_r), .count(count_r),
    .out_valid, .out_ready, .out_inside_res);

  `PIBV_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_inside_res))
  `PIBV_ASSERT_IMP(a_ign, clk, rst_n, out_valid && ignore_r, out_inside_res)
endmodule
